// ===== design/mzipm_pkg.sv =====
package mzipm_pkg;

  localparam logic CMD_POLL = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  // Display power mode values carried in power_code.
  localparam logic [2:0] PWR_ON  = 3'd1;
  localparam logic [2:0] PWR_OFF = 3'd4;

  localparam logic [31:0] IDLE_LIMIT_RESET = 32'd600000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HIT,
    ST_CHECK,
    ST_EMIT
  } mzipm_state_t;

  typedef struct packed {
    logic load;
    logic poll;
    logic hit;
    logic check;
    logic emit;
  } mzipm_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic pending;
    logic out_free;
  } mzipm_status_t;

endpackage

// ===== design/mzipm_ctrl.sv =====
module mzipm_ctrl
  import mzipm_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          command,
  input  mzipm_status_t status,
  output mzipm_cmd_t    cmd,
  output logic          in_ready
);

  mzipm_state_t state;
  mzipm_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && (command == CMD_POLL)) begin
          state_next = ST_HIT;
        end
      end
      ST_HIT: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (status.scan_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!status.pending) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.load  = in_valid && (command == CMD_LOAD);
        cmd.poll  = in_valid && (command == CMD_POLL);
      end
      ST_HIT: begin
        cmd.hit = 1'b1;
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit = status.pending && status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== design/mzipm_dp.sv =====
module mzipm_dp
  import mzipm_pkg::*;
#(
  parameter int NUM_ZONES = 4,
  parameter int ZONE_W    = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  mzipm_cmd_t         cmd,
  output mzipm_status_t      status,
  input  logic [ZONE_W-1:0]  zone_index,
  input  logic signed [15:0] bound_left,
  input  logic signed [15:0] bound_top,
  input  logic signed [15:0] bound_right,
  input  logic signed [15:0] bound_bottom,
  input  logic signed [15:0] cursor_x,
  input  logic signed [15:0] cursor_y,
  input  logic [31:0]        now_ms,
  input  logic               cfg_valid,
  input  logic [31:0]        cfg_data,
  output logic               cfg_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ZONE_W-1:0]  zone_id,
  output logic [2:0]         power_code,
  output logic               last_change
);

  localparam int ZW = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;
  localparam logic [ZONE_W:0] ZONE_COUNT = (ZONE_W + 1)'(NUM_ZONES);
  localparam logic [ZW-1:0] SCAN_LAST = ZW'(NUM_ZONES - 1);

  logic signed [15:0] zone_left   [NUM_ZONES];
  logic signed [15:0] zone_top    [NUM_ZONES];
  logic signed [15:0] zone_right  [NUM_ZONES];
  logic signed [15:0] zone_bottom [NUM_ZONES];
  logic [31:0]        zone_active_time [NUM_ZONES];
  logic [NUM_ZONES-1:0] zone_valid;
  logic [NUM_ZONES-1:0] zone_powered;

  logic signed [15:0] prev_cursor_x;
  logic signed [15:0] prev_cursor_y;
  logic               cursor_seen;
  logic signed [15:0] cur_x;
  logic signed [15:0] cur_y;
  logic [31:0]        cur_now;
  logic               moved;
  logic [31:0]        idle_limit_ms;

  logic [ZW-1:0]        scan;
  logic [NUM_ZONES-1:0] change_mask;

  logic                 load_in_range;
  logic [ZW-1:0]        load_idx;
  logic [NUM_ZONES-1:0] hit;
  logic [NUM_ZONES-1:0] first_hit;
  logic [31:0]          delta;
  logic                 want_on;
  logic                 changed;
  logic [NUM_ZONES-1:0] emit_sel;
  logic [ZW-1:0]        emit_idx;
  logic                 out_free;

  assign cfg_ready     = 1'b1;
  assign load_in_range = {1'b0, zone_index} < ZONE_COUNT;
  assign load_idx      = zone_index[ZW-1:0];
  assign out_free      = !out_valid || out_ready;

  always_comb begin
    for (int i = 0; i < NUM_ZONES; i++) begin
      hit[i] = zone_valid[i] &&
               (cur_x >= zone_left[i]) && (cur_x < zone_right[i]) &&
               (cur_y >= zone_top[i]) && (cur_y < zone_bottom[i]);
    end
  end

  // Two's complement trick isolates the lowest set bit.
  assign first_hit = hit & (~hit + NUM_ZONES'(1));

  // Elapsed time is taken modulo 2^32, so a wrapped tick still works.
  assign delta   = cur_now - zone_active_time[scan];
  assign want_on = delta < idle_limit_ms;
  assign changed = zone_valid[scan] && (want_on != zone_powered[scan]);

  assign emit_sel = change_mask & (~change_mask + NUM_ZONES'(1));

  always_comb begin
    emit_idx = '0;
    for (int i = 0; i < NUM_ZONES; i++) begin
      if (emit_sel[i]) begin
        emit_idx = emit_idx | ZW'(i);
      end
    end
  end

  assign status.scan_last = (scan == SCAN_LAST);
  assign status.pending   = |change_mask;
  assign status.out_free  = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_valid    <= '0;
      zone_powered  <= '0;
      prev_cursor_x <= '0;
      prev_cursor_y <= '0;
      cursor_seen   <= 1'b0;
      change_mask   <= '0;
      out_valid     <= 1'b0;
      idle_limit_ms <= IDLE_LIMIT_RESET;
    end else begin
      if (cfg_valid) begin
        idle_limit_ms <= cfg_data;
      end
      if (cmd.load && load_in_range) begin
        zone_valid[load_idx]   <= 1'b1;
        zone_powered[load_idx] <= 1'b1;
      end
      if (cmd.poll) begin
        prev_cursor_x <= cursor_x;
        prev_cursor_y <= cursor_y;
        cursor_seen   <= 1'b1;
      end
      if (cmd.check && changed) begin
        zone_powered[scan] <= want_on;
        change_mask[scan]  <= 1'b1;
      end
      if (cmd.emit) begin
        change_mask <= change_mask & ~emit_sel;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && load_in_range) begin
      zone_left[load_idx]        <= bound_left;
      zone_top[load_idx]         <= bound_top;
      zone_right[load_idx]       <= bound_right;
      zone_bottom[load_idx]      <= bound_bottom;
      zone_active_time[load_idx] <= now_ms;
    end
    if (cmd.poll) begin
      cur_x   <= cursor_x;
      cur_y   <= cursor_y;
      cur_now <= now_ms;
      moved   <= cursor_seen &&
                 ((cursor_x != prev_cursor_x) || (cursor_y != prev_cursor_y));
      scan    <= '0;
    end
    if (cmd.hit && moved) begin
      for (int i = 0; i < NUM_ZONES; i++) begin
        if (first_hit[i]) begin
          zone_active_time[i] <= cur_now;
        end
      end
    end
    if (cmd.check) begin
      scan <= scan + ZW'(1);
    end
    if (cmd.emit) begin
      zone_id     <= ZONE_W'(emit_idx);
      power_code  <= zone_powered[emit_idx] ? PWR_ON : PWR_OFF;
      last_change <= ((change_mask & ~emit_sel) == '0);
    end
  end

  a_mask_only_valid: assert property (@(posedge clk) disable iff (rst)
    (change_mask & ~zone_valid) == '0)
    else $error("power change pending for a zone that was never loaded");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> out_free)
    else $error("result issued while the output register is still occupied");

  a_poll_starts_clean: assert property (@(posedge clk) disable iff (rst)
    cmd.poll |-> (change_mask == '0))
    else $error("poll accepted before the previous changes were all issued");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("issued result did not appear on the output");

endmodule

// ===== design/multi_zone_idle_power_manager_unit.sv =====
// Idle power manager for up to NUM_ZONES rectangular display zones. A load
// transfer writes one zone's bounds, turns it on and stamps its activity time;
// it gives no result. A poll transfer hit-tests the cursor against all zones
// at once, then checks the zones one per cycle through a single elapsed-time
// subtract and compare, and then issues one result per power change, the last
// one marked by last_change. A poll occupies the block through its hit, check
// and emit states, and longer while the output transfer is held off. The next
// item can be taken while the final result still waits in the output register.
module multi_zone_idle_power_manager_unit
  import mzipm_pkg::*;
#(
  parameter int NUM_ZONES = 4,
  parameter int ZONE_W    = (NUM_ZONES > 4) ? $clog2(NUM_ZONES) : 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               command,
  input  logic [ZONE_W-1:0]  zone_index,
  input  logic signed [15:0] bound_left,
  input  logic signed [15:0] bound_top,
  input  logic signed [15:0] bound_right,
  input  logic signed [15:0] bound_bottom,
  input  logic signed [15:0] cursor_x,
  input  logic signed [15:0] cursor_y,
  input  logic [31:0]        now_ms,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ZONE_W-1:0]  zone_id,
  output logic [2:0]         power_code,
  output logic               last_change
);

  mzipm_cmd_t    cmd;
  mzipm_status_t status;

  mzipm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (command),
    .status   (status),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  mzipm_dp #(
    .NUM_ZONES (NUM_ZONES),
    .ZONE_W    (ZONE_W)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .zone_index   (zone_index),
    .bound_left   (bound_left),
    .bound_top    (bound_top),
    .bound_right  (bound_right),
    .bound_bottom (bound_bottom),
    .cursor_x     (cursor_x),
    .cursor_y     (cursor_y),
    .now_ms       (now_ms),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .cfg_ready    (cfg_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .zone_id      (zone_id),
    .power_code   (power_code),
    .last_change  (last_change)
  );

endmodule

// ===== tb/sv/tb_multi_zone_idle_power_manager_unit.sv =====
`timescale 1ns / 100ps

module tb_multi_zone_idle_power_manager_unit;
  import mzipm_pkg::*;

  localparam int ZONES = 4;
  localparam int SETTLE_CYCLES = 24;

  typedef struct packed {
    logic               command;
    logic [1:0]         zone_index;
    logic signed [15:0] bound_left;
    logic signed [15:0] bound_top;
    logic signed [15:0] bound_right;
    logic signed [15:0] bound_bottom;
    logic signed [15:0] cursor_x;
    logic signed [15:0] cursor_y;
    logic [31:0]        now_ms;
  } zone_item_t;

  typedef struct packed {
    logic [1:0] zone;
    logic [2:0] code;
    logic       last;
  } power_change_t;

  class power_scoreboard;
    logic signed [15:0] z_left [ZONES];
    logic signed [15:0] z_top [ZONES];
    logic signed [15:0] z_right [ZONES];
    logic signed [15:0] z_bottom [ZONES];
    logic [31:0]        z_stamp [ZONES];
    bit                 z_valid [ZONES];
    bit                 z_on [ZONES];
    logic signed [15:0] cur_x;
    logic signed [15:0] cur_y;
    bit                 cur_seen;
    logic [31:0]        idle_limit;
    power_change_t      change_q[$];
    int errors;
    int loads;
    int polls;
    int changes;
    int offs;

    function new();
      for (int i = 0; i < ZONES; i++) begin
        z_left[i] = '0;
        z_top[i] = '0;
        z_right[i] = '0;
        z_bottom[i] = '0;
        z_stamp[i] = '0;
        z_valid[i] = 1'b0;
        z_on[i] = 1'b0;
      end
      cur_x = '0;
      cur_y = '0;
      cur_seen = 1'b0;
      idle_limit = IDLE_LIMIT_RESET;
      errors = 0;
      loads = 0;
      polls = 0;
      changes = 0;
      offs = 0;
    endfunction

    function int pending();
      return change_q.size();
    endfunction

    function void queue_change(power_change_t ch);
      change_q.insert(change_q.size(), ch);
    endfunction

    // Applies one accepted transfer to the zone state and queues the power
    // changes that it causes, in zone order.
    function void note_item(zone_item_t it);
      logic signed [15:0] px;
      logic signed [15:0] py;
      logic [31:0]        elapsed;
      bit                 moved;
      bit                 hit;
      bit                 want_on;
      power_change_t      ch;
      power_change_t      batch [ZONES];
      int                 nb;
      if (it.command == CMD_LOAD) begin
        z_left[it.zone_index] = it.bound_left;
        z_top[it.zone_index] = it.bound_top;
        z_right[it.zone_index] = it.bound_right;
        z_bottom[it.zone_index] = it.bound_bottom;
        z_stamp[it.zone_index] = it.now_ms;
        z_valid[it.zone_index] = 1'b1;
        z_on[it.zone_index] = 1'b1;
        loads++;
        return;
      end
      polls++;
      nb = 0;
      px = it.cursor_x;
      py = it.cursor_y;
      moved = cur_seen && (px != cur_x || py != cur_y);
      cur_x = px;
      cur_y = py;
      cur_seen = 1'b1;
      hit = 1'b0;
      if (moved) begin
        for (int i = 0; i < ZONES; i++) begin
          if (!hit && z_valid[i] && px >= z_left[i] && px < z_right[i] &&
              py >= z_top[i] && py < z_bottom[i]) begin
            z_stamp[i] = it.now_ms;
            hit = 1'b1;
          end
        end
      end
      for (int i = 0; i < ZONES; i++) begin
        if (z_valid[i]) begin
          elapsed = it.now_ms - z_stamp[i];
          want_on = elapsed < idle_limit;
          if (want_on != z_on[i]) begin
            z_on[i] = want_on;
            ch.zone = 2'(i);
            ch.code = want_on ? PWR_ON : PWR_OFF;
            ch.last = 1'b0;
            batch[nb] = ch;
            nb++;
          end
        end
      end
      for (int k = 0; k < nb; k++) begin
        ch = batch[k];
        ch.last = (k == nb - 1);
        queue_change(ch);
      end
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [1:0] zone, logic [2:0] code, logic last);
      power_change_t want;
      if (change_q.size() == 0) begin
        report($sformatf("unexpected result zone_id %0d power_code %0d last_change %0d",
                         zone, code, last));
        return;
      end
      want = change_q.pop_front();
      changes++;
      if (want.code == PWR_OFF) offs++;
      if (zone !== want.zone)
        report($sformatf("zone_id %0d, expected %0d", zone, want.zone));
      if (code !== want.code)
        report($sformatf("power_code %0d for zone %0d, expected %0d",
                         code, want.zone, want.code));
      if (last !== want.last)
        report($sformatf("last_change %0d for zone %0d, expected %0d",
                         last, want.zone, want.last));
    endtask
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic               command;
  logic [1:0]         zone_index;
  logic signed [15:0] bound_left;
  logic signed [15:0] bound_top;
  logic signed [15:0] bound_right;
  logic signed [15:0] bound_bottom;
  logic signed [15:0] cursor_x;
  logic signed [15:0] cursor_y;
  logic [31:0]        now_ms;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [31:0]        cfg_data;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         zone_id;
  logic [2:0]         power_code;
  logic               last_change;

  power_scoreboard sb = new();

  int          burst_left;
  int          settings;
  logic [31:0] cur_limit;
  logic [31:0] clock_ms;
  int          lay_l [ZONES];
  int          lay_t [ZONES];
  int          lay_r [ZONES];
  int          lay_b [ZONES];
  int          last_x;
  int          last_y;
  int          rx_mode;
  int          rx_left;
  int          rx_tick;

  multi_zone_idle_power_manager_unit uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .zone_index   (zone_index),
    .bound_left   (bound_left),
    .bound_top    (bound_top),
    .bound_right  (bound_right),
    .bound_bottom (bound_bottom),
    .cursor_x     (cursor_x),
    .cursor_y     (cursor_y),
    .now_ms       (now_ms),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .zone_id      (zone_id),
    .power_code   (power_code),
    .last_change  (last_change)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #10_000_000;
    $display("tb_multi_zone_idle_power_manager_unit: errors");
    $finish;
  end

  // Receiver: the stall pattern switches among always ready, random,
  // one cycle in four, and one cycle in thirteen.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(zone_id, power_code, last_change);
    if (rx_left <= 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 80);
    end else begin
      rx_left--;
    end
    rx_tick++;
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (rx_tick % 4 == 0);
      default: out_ready <= (rx_tick % 13 == 0);
    endcase
  end

  // Fields that the command does not use are filled with noise.
  function automatic zone_item_t noise_item();
    zone_item_t it;
    it.command = 1'($urandom);
    it.zone_index = 2'($urandom);
    it.bound_left = 16'($urandom);
    it.bound_top = 16'($urandom);
    it.bound_right = 16'($urandom);
    it.bound_bottom = 16'($urandom);
    it.cursor_x = 16'($urandom);
    it.cursor_y = 16'($urandom);
    it.now_ms = $urandom;
    return it;
  endfunction

  function automatic zone_item_t load_item(int idx, int l, int t, int r, int b,
                                           logic [31:0] at);
    zone_item_t it;
    it = noise_item();
    it.command = CMD_LOAD;
    it.zone_index = 2'(idx);
    it.bound_left = 16'(l);
    it.bound_top = 16'(t);
    it.bound_right = 16'(r);
    it.bound_bottom = 16'(b);
    it.now_ms = at;
    return it;
  endfunction

  function automatic zone_item_t poll_item(int x, int y, logic [31:0] at);
    zone_item_t it;
    it = noise_item();
    it.command = CMD_POLL;
    it.cursor_x = 16'(x);
    it.cursor_y = 16'(y);
    it.now_ms = at;
    return it;
  endfunction

  // Offers one item, holds it until the transfer, and then idles the input
  // between bursts.
  task automatic send_paced(zone_item_t it);
    int gap;
    in_valid <= 1'b1;
    command <= it.command;
    zone_index <= it.zone_index;
    bound_left <= it.bound_left;
    bound_top <= it.bound_top;
    bound_right <= it.bound_right;
    bound_bottom <= it.bound_bottom;
    cursor_x <= it.cursor_x;
    cursor_y <= it.cursor_y;
    now_ms <= it.now_ms;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(it);
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 25) : $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 10);
    end
  endtask

  // Waits until every queued change has come out and the block has settled.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idle_limit(logic [31:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.idle_limit = value;
    cur_limit = value;
    settings++;
  endtask

  // Loads a zone, mostly with a proper rectangle; when tidy is clear it may
  // also be random, the whole plane, or empty.
  task automatic random_load(int idx, bit tidy);
    int kind;
    int w;
    int h;
    kind = tidy ? 0 : $urandom_range(0, 9);
    if (kind <= 6) begin
      w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40000) : $urandom_range(1, 3000);
      h = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40000) : $urandom_range(1, 3000);
      lay_l[idx] = $urandom_range(0, 65534) - 32768;
      lay_t[idx] = $urandom_range(0, 65534) - 32768;
      lay_r[idx] = (lay_l[idx] + w > 32767) ? 32767 : lay_l[idx] + w;
      lay_b[idx] = (lay_t[idx] + h > 32767) ? 32767 : lay_t[idx] + h;
    end else if (kind == 7) begin
      lay_l[idx] = $urandom_range(0, 65535) - 32768;
      lay_t[idx] = $urandom_range(0, 65535) - 32768;
      lay_r[idx] = $urandom_range(0, 65535) - 32768;
      lay_b[idx] = $urandom_range(0, 65535) - 32768;
    end else if (kind == 8) begin
      lay_l[idx] = -32768;
      lay_t[idx] = -32768;
      lay_r[idx] = 32767;
      lay_b[idx] = 32767;
    end else begin
      lay_l[idx] = $urandom_range(0, 65535) - 32768;
      lay_t[idx] = $urandom_range(0, 65535) - 32768;
      lay_r[idx] = lay_l[idx];
      lay_b[idx] = lay_t[idx] + 5;
    end
    send_paced(load_item(idx, lay_l[idx], lay_t[idx], lay_r[idx], lay_b[idx], clock_ms));
  endtask

  // Four zones are loaded first; then mostly polls whose time advances by
  // steps scaled to the idle limit, with a cursor that usually lands in a zone.
  task automatic run_phase(int n_items);
    int          pick;
    int          k;
    int          x;
    int          y;
    logic [31:0] step;
    logic [31:0] at;
    for (int z = 0; z < ZONES; z++) random_load(z, 1'b1);
    repeat (n_items - ZONES) begin
      if ($urandom_range(0, 99) < 12) begin
        random_load($urandom_range(0, ZONES - 1), 1'b0);
      end else begin
        case ($urandom_range(0, 9))
          0: step = '0;
          1, 2, 3, 4: step = $urandom_range(0, cur_limit >> 2);
          5, 6, 7: step = $urandom_range(cur_limit >> 1,
                                         (cur_limit > 32'h7fffffff) ? 32'hffffffff
                                                                    : cur_limit << 1);
          8: step = cur_limit - $urandom_range(0, 1);
          default: step = $urandom;
        endcase
        clock_ms = clock_ms + step;
        at = ($urandom_range(0, 19) == 0) ? $urandom : clock_ms;
        pick = $urandom_range(0, 99);
        k = $urandom_range(0, ZONES - 1);
        if (pick < 60 && lay_r[k] > lay_l[k] && lay_b[k] > lay_t[k]) begin
          x = lay_l[k] + $urandom_range(0, lay_r[k] - lay_l[k] - 1);
          y = lay_t[k] + $urandom_range(0, lay_b[k] - lay_t[k] - 1);
        end else if (pick < 75) begin
          x = last_x;
          y = last_y;
        end else if (pick < 80) begin
          x = $urandom_range(0, 1) ? 32767 : -32768;
          y = $urandom_range(0, 1) ? 32767 : -32768;
        end else begin
          x = $urandom_range(0, 65535) - 32768;
          y = $urandom_range(0, 65535) - 32768;
        end
        last_x = x;
        last_y = y;
        send_paced(poll_item(x, y, at));
      end
    end
  endtask

  initial begin
    logic [31:0] limits [6];
    rst <= 1'b1;
    in_valid <= 1'b0;
    command <= CMD_POLL;
    zone_index <= '0;
    bound_left <= '0;
    bound_top <= '0;
    bound_right <= '0;
    bound_bottom <= '0;
    cursor_x <= '0;
    cursor_y <= '0;
    now_ms <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    out_ready <= 1'b0;
    burst_left = 4;
    settings = 0;
    cur_limit = IDLE_LIMIT_RESET;
    clock_ms = $urandom;
    last_x = 0;
    last_y = 0;
    rx_mode = 0;
    rx_left = 0;
    rx_tick = 0;
    for (int z = 0; z < ZONES; z++) begin
      lay_l[z] = 0;
      lay_t[z] = 0;
      lay_r[z] = 0;
      lay_b[z] = 0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: a plane-wide zone, a zone inside it, an empty and an
    // inverted zone. The first poll only records the cursor, so all four
    // time out together.
    set_idle_limit(IDLE_LIMIT_RESET);
    send_paced(load_item(0, -32768, -32768, 32767, 32767, 32'd100));
    send_paced(load_item(1, 0, 0, 100, 100, 32'd100));
    send_paced(load_item(2, 50, 50, 50, 90, 32'd100));
    send_paced(load_item(3, 200, 200, 10, 10, 32'd100));
    send_paced(poll_item(5, 5, 32'd600100));
    send_paced(poll_item(5, 5, 32'd600110));
    send_paced(poll_item(6, 6, 32'd600120));
    send_paced(poll_item(32767, 0, 32'd600130));
    send_paced(poll_item(50, 50, 32'd600140));
    send_paced(poll_item(100, 50, 32'd600150));
    send_paced(poll_item(-32768, -32768, 32'd1200119));
    send_paced(poll_item(-32768, -32768, 32'd1800200));
    // Elapsed time across the wrap of the millisecond tick.
    send_paced(load_item(2, -10, -10, 10, 10, 32'hffffff00));
    send_paced(poll_item(0, 0, 32'h00000100));
    set_idle_limit(32'd1);
    send_paced(poll_item(0, 0, 32'h00000100));
    send_paced(load_item(3, -32768, -32768, 32767, 32767, 32'd500));
    set_idle_limit(32'hffffffff);
    send_paced(poll_item(1, 1, 32'd499));
    // A zero limit turns every valid zone off.
    set_idle_limit(32'd0);
    send_paced(poll_item(2, 2, 32'd600));
    send_paced(load_item(1, 32767, 32767, -32768, -32768, 32'd700));
    send_paced(poll_item(32767, 32767, 32'd700));

    limits[0] = 32'd1;
    limits[1] = $urandom_range(20, 5000);
    limits[2] = 32'hffffffff;
    limits[3] = 32'd0;
    limits[4] = IDLE_LIMIT_RESET;
    limits[5] = $urandom;
    for (int p = 0; p < 6; p++) begin
      set_idle_limit(limits[p]);
      run_phase(44);
    end

    wait_idle();
    $display("Run covered %0d zone loads and %0d polls over %0d idle-limit settings.",
             sb.loads, sb.polls, settings);
    $display("%0d power changes were checked, %0d of them to off.", sb.changes, sb.offs);
    if (sb.errors == 0) begin
      $display("tb_multi_zone_idle_power_manager_unit: clean");
    end else begin
      $display("tb_multi_zone_idle_power_manager_unit: errors");
    end
    $finish;
  end

endmodule

// ===== multi_zone_idle_power_manager_unit.f =====
design/mzipm_pkg.sv
design/mzipm_ctrl.sv
design/mzipm_dp.sv
design/multi_zone_idle_power_manager_unit.sv
tb/sv/tb_multi_zone_idle_power_manager_unit.sv
